### src/amlt_pkg.sv
package amlt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AVG_DEPTH   = 8;

    localparam int SLOT_W  = $clog2(AVG_DEPTH);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(AVG_DEPTH);

    // floor(u / AVG_DEPTH) == (u * RECIP) >> RECIP_SHIFT for every SUM_W-bit u
    localparam int RECIP_SHIFT = SUM_W + $clog2(AVG_DEPTH);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
    localparam logic [SUM_W-1:0] AVG_BIAS = SUM_W'(AVG_DEPTH) << (SAMPLE_BITS - 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [PADDR_W-3:0] {
        REG_START_LEVEL = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        CROSS_NONE = 2'd0,
        CROSS_RISE = 2'd1,
        CROSS_FALL = 2'd2
    } crossing_t;

    typedef struct packed {
        sample_t   midpoint;
        logic      level;
        crossing_t crossing;
        sample_t   peak_average;
        sample_t   valley_average;
    } result_t;

    function automatic sample_t midpoint(input sample_t a, input sample_t b);
        logic signed [SAMPLE_BITS:0] t;
        t = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
        return t[SAMPLE_BITS:1];
    endfunction

    // floor(sum / AVG_DEPTH): bias to unsigned, reciprocal multiply, unbias
    function automatic sample_t floor_avg(input sum_t sum);
        logic [SUM_W-1:0]       biased;
        logic [2*SUM_W:0]       prod;
        logic [SAMPLE_BITS-1:0] q;
        biased = $unsigned(sum) + AVG_BIAS;
        prod   = {{(SUM_W+1){1'b0}}, biased} * {{SUM_W{1'b0}}, RECIP};
        q      = prod[RECIP_SHIFT +: SAMPLE_BITS];
        return {~q[SAMPLE_BITS-1], q[SAMPLE_BITS-2:0]};
    endfunction

endpackage

### src/adaptive_midpoint_level_tracker.sv
// Adaptive midpoint level tracker: one signed sample is accepted per clock while
// s_ready is high; its result word is registered in p1, then with the ring
// averages in the output buffer. Running max/min and the level are updated in
// the accept cycle; each peak/valley ring lives in a RAM whose next slot is
// prefetched, so a push replaces the evicted word in the running sum without a
// stall. Ring entries read as zero until written; no clearing pass runs after
// reset. A two-word buffer keeps s_ready high while m_ready stalls, until full.
module adaptive_midpoint_level_tracker
    import amlt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_midpoint,
    output logic                   m_level,
    output logic [1:0]             m_crossing,
    output logic [SAMPLE_BITS-1:0] m_peak_average,
    output logic [SAMPLE_BITS-1:0] m_valley_average,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic      start_level_reg;
    logic      level_reg;
    sample_t   max_reg;
    sample_t   min_reg;

    logic      p1_valid_reg;
    sample_t   p1_mid_reg;
    logic      p1_level_reg;
    crossing_t p1_cross_reg;

    logic      out_valid_reg;
    result_t   out_reg;
    logic      skid_valid_reg;
    result_t   skid_reg;

    logic      accept;
    logic      cfg_wr;
    logic      p1_adv;
    sample_t   sample;
    sample_t   max_upd;
    sample_t   min_upd;
    sample_t   mid;
    logic      level_new;
    logic      rise;
    logic      fall;
    crossing_t cross_kind;
    sum_t      peak_sum;
    sum_t      valley_sum;
    result_t   res_new;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_START_LEVEL);
    assign prdata = (paddr[PADDR_W-1:2] == REG_START_LEVEL) ?
                    {{(PDATA_W-1){1'b0}}, start_level_reg} : '0;

    assign s_ready = !p1_valid_reg || !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign p1_adv  = p1_valid_reg && !skid_valid_reg;

    always_comb begin
        sample     = sample_t'(s_sample);
        max_upd    = (sample > max_reg) ? sample : max_reg;
        min_upd    = (sample < min_reg) ? sample : min_reg;
        mid        = midpoint(max_upd, min_upd);
        level_new  = level_reg ? !(sample < mid) : (sample > mid);
        rise       = !level_reg && level_new;
        fall       = level_reg && !level_new;
        cross_kind = rise ? CROSS_RISE : (fall ? CROSS_FALL : CROSS_NONE);
    end

    amlt_ring u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && fall),
        .push_data (max_upd),
        .sum       (peak_sum)
    );

    amlt_ring u_valley (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && rise),
        .push_data (min_upd),
        .sum       (valley_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_level_reg <= 1'b0;
            level_reg       <= 1'b0;
            max_reg         <= SAMPLE_MIN;
            min_reg         <= SAMPLE_MAX;
        end else if (cfg_wr) begin
            start_level_reg <= pwdata[0];
            level_reg       <= pwdata[0];
        end else if (accept) begin
            level_reg <= level_new;
            max_reg   <= fall ? SAMPLE_MIN : max_upd;
            min_reg   <= rise ? SAMPLE_MAX : min_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_mid_reg   <= mid;
            p1_level_reg <= level_new;
            p1_cross_reg <= cross_kind;
        end
    end

    // ring sums still reflect the word in p1 until it moves on
    always_comb begin
        res_new.midpoint       = p1_mid_reg;
        res_new.level          = p1_level_reg;
        res_new.crossing       = p1_cross_reg;
        res_new.peak_average   = floor_avg(peak_sum);
        res_new.valley_average = floor_avg(valley_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= p1_adv;
            end
        end else if (p1_adv) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (p1_adv) begin
                out_reg <= res_new;
            end
        end else if (p1_adv) begin
            skid_reg <= res_new;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_midpoint       = out_reg.midpoint;
    assign m_level          = out_reg.level;
    assign m_crossing       = out_reg.crossing;
    assign m_peak_average   = out_reg.peak_average;
    assign m_valley_average = out_reg.valley_average;

endmodule

### src/amlt_ram.sv
module amlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/amlt_ring.sv
module amlt_ring
    import amlt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  sample_t push_data,
    output sum_t    sum
);

    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [SLOT_W-1:0]    slot_inc;
    logic [AVG_DEPTH-1:0] valid_reg;
    sum_t                 sum_reg;
    sum_t                 sum_next;
    logic [SAMPLE_BITS-1:0] rdata;
    sample_t              old_word;

    // next slot is prefetched so the evicted word is ready when a push comes
    amlt_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (AVG_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (slot_reg),
        .wdata (push_data),
        .raddr (slot_next),
        .rdata (rdata)
    );

    always_comb begin
        slot_inc  = (slot_reg == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        slot_next = push ? slot_inc : slot_reg;
        old_word  = valid_reg[slot_reg] ? sample_t'(rdata) : '0;
        sum_next  = sum_reg;
        if (push) begin
            sum_next = sum_reg
                - {{(SUM_W-SAMPLE_BITS){old_word[SAMPLE_BITS-1]}}, old_word}
                + {{(SUM_W-SAMPLE_BITS){push_data[SAMPLE_BITS-1]}}, push_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            valid_reg <= '0;
            sum_reg   <= '0;
        end else begin
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            if (push) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    assign sum = sum_reg;

endmodule

### src/amlt_checker.sv
module amlt_checker
    import amlt_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [SAMPLE_BITS-1:0] s_sample,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_midpoint,
    input logic                   m_level,
    input logic [1:0]             m_crossing,
    input logic [SAMPLE_BITS-1:0] m_peak_average,
    input logic [SAMPLE_BITS-1:0] m_valley_average,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [PADDR_W-1:0]     paddr,
    input logic [PDATA_W-1:0]     pwdata,
    input logic [PDATA_W-1:0]     prdata,
    input logic                   pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_midpoint) && $stable(m_level)
            && $stable(m_crossing) && $stable(m_peak_average)
            && $stable(m_valley_average))
        else $error("result word changed while stalled");

    a_rise_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_crossing == CROSS_RISE) |-> m_level)
        else $error("rise reported with low level");

    a_fall_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_crossing == CROSS_FALL) |-> !m_level)
        else $error("fall reported with high level");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_START_LEVEL))
        ##1 (psel && !pwrite && (paddr[PADDR_W-1:2] == REG_START_LEVEL))
        |-> prdata[0] == $past(pwdata[0]))
        else $error("start_level readback mismatch");

endmodule

bind adaptive_midpoint_level_tracker amlt_checker u_amlt_checker (.*);

### test/amlt_checker.sv
`timescale 1ns / 100ps

module amlt_scoreboard
    import amlt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [SAMPLE_BITS-1:0] m_midpoint,
    input  logic                   m_level,
    input  logic [1:0]             m_crossing,
    input  logic [SAMPLE_BITS-1:0] m_peak_average,
    input  logic [SAMPLE_BITS-1:0] m_valley_average,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic [PDATA_W-1:0]     prdata,
    input  logic                   pready,

    output int                     mismatches,
    output int                     words_due
);

    sample_t peak_hist   [AVG_DEPTH];
    sample_t valley_hist [AVG_DEPTH];
    int      peak_total;
    int      valley_total;
    int      peak_next;
    int      valley_next;
    sample_t hi_mark;
    sample_t lo_mark;
    logic    level_now;
    logic    level_seen;
    logic    start_bit;
    result_t level_words [$];

    function automatic int floor_by(input int num, input int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic void clear_tracker();
        hi_mark      = SAMPLE_MIN;
        lo_mark      = SAMPLE_MAX;
        start_bit    = 1'b0;
        level_now    = 1'b0;
        level_seen   = 1'b0;
        peak_total   = 0;
        valley_total = 0;
        peak_next    = 0;
        valley_next  = 0;
        for (int i = 0; i < AVG_DEPTH; i++) begin
            peak_hist[i]   = '0;
            valley_hist[i] = '0;
        end
    endfunction

    function automatic result_t track_sample(input sample_t s);
        result_t r;
        int      mid;
        r.crossing = CROSS_NONE;
        if (s > hi_mark) begin
            hi_mark = s;
        end
        if (s < lo_mark) begin
            lo_mark = s;
        end
        mid = floor_by(int'(hi_mark) + int'(lo_mark), 2);

        if (!level_now && int'(s) > mid) begin
            level_now = 1'b1;
        end else if (level_now && int'(s) < mid) begin
            level_now = 1'b0;
        end

        if (level_now != level_seen) begin
            level_seen = level_now;
            if (!level_now) begin
                r.crossing = CROSS_FALL;
                peak_total = peak_total - int'(peak_hist[peak_next]) + int'(hi_mark);
                peak_hist[peak_next] = hi_mark;
                peak_next = (peak_next + 1) % AVG_DEPTH;
                hi_mark = SAMPLE_MIN;
            end else begin
                r.crossing = CROSS_RISE;
                valley_total = valley_total - int'(valley_hist[valley_next]) + int'(lo_mark);
                valley_hist[valley_next] = lo_mark;
                valley_next = (valley_next + 1) % AVG_DEPTH;
                lo_mark = SAMPLE_MAX;
            end
        end

        r.midpoint       = sample_t'(mid);
        r.level          = level_now;
        r.peak_average   = sample_t'(floor_by(peak_total, AVG_DEPTH));
        r.valley_average = sample_t'(floor_by(valley_total, AVG_DEPTH));
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        int      errs;
        errs = 0;
        if (!aresetn) begin
            clear_tracker();
            level_words.delete();
        end else begin
            if (psel && penable && pready && paddr[1:0] == 2'b00
                    && paddr[PADDR_W-1:2] == REG_START_LEVEL) begin
                if (pwrite) begin
                    start_bit  = pwdata[0];
                    level_now  = pwdata[0];
                    level_seen = pwdata[0];
                end else if (prdata !== {{(PDATA_W-1){1'b0}}, start_bit}) begin
                    $display("%0t start_level read expected %0h got %0h",
                             $time, start_bit, prdata);
                    errs = errs + 1;
                end
            end

            if (s_valid && s_ready) begin
                level_words.push_back(track_sample(sample_t'(s_sample)));
            end

            if (m_valid && m_ready) begin
                if (level_words.size() == 0) begin
                    $display("%0t unexpected word: midpoint %0d level %0d crossing %0d",
                             $time, $signed(m_midpoint), m_level, m_crossing);
                    errs = errs + 1;
                end else begin
                    want = level_words.pop_front();
                    if (want.midpoint !== m_midpoint
                            || want.level !== m_level
                            || want.crossing !== m_crossing
                            || want.peak_average !== m_peak_average
                            || want.valley_average !== m_valley_average) begin
                        errs = errs + 1;
                        if (want.midpoint !== m_midpoint)
                            $display("%0t midpoint expected %0d got %0d",
                                     $time, want.midpoint, $signed(m_midpoint));
                        if (want.level !== m_level)
                            $display("%0t level expected %0d got %0d",
                                     $time, want.level, m_level);
                        if (want.crossing !== m_crossing)
                            $display("%0t crossing expected %0d got %0d",
                                     $time, want.crossing, m_crossing);
                        if (want.peak_average !== m_peak_average)
                            $display("%0t peak_average expected %0d got %0d",
                                     $time, want.peak_average, $signed(m_peak_average));
                        if (want.valley_average !== m_valley_average)
                            $display("%0t valley_average expected %0d got %0d",
                                     $time, want.valley_average, $signed(m_valley_average));
                    end
                end
            end
        end
        if (errs != 0) begin
            mismatches <= mismatches + errs;
        end
        words_due <= level_words.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import amlt_pkg::*;

    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 180;

    logic                   aclk;
    logic                   aresetn          = 1'b0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_sample         = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic [SAMPLE_BITS-1:0] m_midpoint;
    logic                   m_level;
    logic [1:0]             m_crossing;
    logic [SAMPLE_BITS-1:0] m_peak_average;
    logic [SAMPLE_BITS-1:0] m_valley_average;
    logic                   psel             = 1'b0;
    logic                   penable          = 1'b0;
    logic                   pwrite           = 1'b0;
    logic [PADDR_W-1:0]     paddr            = '0;
    logic [PDATA_W-1:0]     pwdata           = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int   mismatches;
    int   words_due;
    logic calm     = 1'b0;
    logic hold_req = 1'b0;
    int   wave_pos  = 0;
    int   wave_goal = 0;
    int   wave_step = 1;

    localparam logic [PADDR_W-1:0] START_ADDR  = {REG_START_LEVEL, 2'b00};
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_START_LEVEL, 2'b00};

    adaptive_midpoint_level_tracker dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_midpoint       (m_midpoint),
        .m_level          (m_level),
        .m_crossing       (m_crossing),
        .m_peak_average   (m_peak_average),
        .m_valley_average (m_valley_average),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    amlt_scoreboard u_scoreboard (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_midpoint       (m_midpoint),
        .m_level          (m_level),
        .m_crossing       (m_crossing),
        .m_peak_average   (m_peak_average),
        .m_valley_average (m_valley_average),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .words_due        (words_due)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly a wandering waveform so the level keeps crossing, some noise and rails
    function automatic sample_t next_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 12) return sample_t'($urandom);
        if (r < 16) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        if (wave_pos == wave_goal) begin
            wave_goal = int'($urandom_range(0, 65535)) - 32768;
            wave_step = $urandom_range(0, 3) == 0 ? $urandom_range(1, 64)
                                                  : $urandom_range(256, 8192);
        end
        if (wave_pos < wave_goal)
            wave_pos = (wave_goal - wave_pos > wave_step) ? wave_pos + wave_step : wave_goal;
        else
            wave_pos = (wave_pos - wave_goal > wave_step) ? wave_pos - wave_step : wave_goal;
        v = wave_pos + int'($urandom_range(0, 31)) - 16;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return sample_t'(v);
    endfunction

    task automatic push_sample(input sample_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : receiver
        int stall;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT) @(posedge aclk);
        $display("adaptive_midpoint_level_tracker verification failed");
        $finish;
    end

    initial begin : stimulus
        sample_t directed [$];
        logic    lvl;
        directed = '{16'sd10, 16'sd20, 16'sd20, 16'sd0,
                     SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                     16'sd0, -16'sd1, 16'sd1, -16'sd1,
                     SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                     SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                     SAMPLE_MAX, SAMPLE_MIN};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        reg_access(1'b0, START_ADDR, '0);
        foreach (directed[i]) push_sample(directed[i]);
        settle();

        reg_access(1'b1, UNUSED_ADDR, $urandom);
        reg_access(1'b1, START_ADDR, 32'h1);
        reg_access(1'b0, START_ADDR, '0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MIN);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: lvl = 1'b0;
                1: lvl = 1'b1;
                default: lvl = 1'($urandom_range(0, 1));
            endcase
            reg_access(1'b1, START_ADDR, PDATA_W'({$urandom, 1'b0}) | PDATA_W'(lvl));
            reg_access(1'b0, START_ADDR, '0);
            if (ph == 4) reg_access(1'b1, UNUSED_ADDR, $urandom);
            calm = (ph == 2);
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) push_sample(next_sample());
            settle();
        end

        settle();
        repeat (12) @(posedge aclk);
        if (mismatches == 0)
            $display("adaptive_midpoint_level_tracker verification clean");
        else
            $display("adaptive_midpoint_level_tracker verification failed");
        $finish;
    end

endmodule
